@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/qcsv_pkg.sv @@
// Types, constants and functions (byte step, field limit, line-break test) of the quoted CSV field splitter.
package qcsv_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] FIELDS_MAX = CNT_W'(MAX_FIELDS);
  localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(MAX_FIELDS + 1);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  localparam logic [7:0]       DELIM_RST    = 8'd44;
  localparam logic [CNT_W-1:0] EXPECTED_RST = CNT_W'(1);

  localparam logic REG_DELIMITER = 1'b0;
  localparam logic REG_EXPECTED  = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_END     = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MANY = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  typedef struct packed {
    logic             in_quote;
    logic             field_closed;
    logic [CNT_W-1:0] counter;
  } pstate_t;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] field_index;
    logic [7:0]       data_byte;
    status_t          status;
    logic [CNT_W-1:0] token_count;
    logic             run_last;
  } result_t;

  typedef struct packed {
    pstate_t st;
    logic    emit;
    result_t res;
  } step_t;

  // Up to three tail bytes plus line done per input word.
  typedef struct packed {
    result_t [3:0] res;
    logic [2:0]    count;
  } batch_t;

  function automatic logic [CNT_W-1:0] eff_expected(logic [CNT_W-1:0] e);
    logic [CNT_W-1:0] r;
    if (e == '0) r = CNT_ONE;
    else if (e > FIELDS_MAX) r = FIELDS_MAX;
    else r = e;
    return r;
  endfunction

  function automatic logic is_crlf(logic [7:0] b);
    return (b == CR_BYTE) || (b == LF_BYTE);
  endfunction

  function automatic step_t process_byte(pstate_t st, logic [7:0] b,
                                         logic [7:0] delim, logic [CNT_W-1:0] eff);
    step_t r;
    logic  kept;
    kept = (st.counter <= eff);
    r = '0;
    r.st = st;
    r.res.kind = KIND_BYTE;
    r.res.field_index = st.counter;
    r.res.status = ST_OK;
    if (b == QUOTE_BYTE) begin
      if (!st.in_quote) begin
        r.emit = kept;
        r.res.kind = KIND_RESTART;
        r.st.field_closed = 1'b0;
        r.st.in_quote = 1'b1;
      end else begin
        r.st.in_quote = 1'b0;
        r.st.field_closed = 1'b1;
      end
    end else if (b == delim && !st.in_quote) begin
      r.emit = kept;
      r.res.kind = KIND_END;
      r.st.field_closed = 1'b0;
      if (st.counter < CNT_SAT) r.st.counter = st.counter + CNT_ONE;
    end else begin
      r.emit = kept && !st.field_closed;
      r.res.data_byte = b;
    end
    return r;
  endfunction

endpackage

@@ hdl/qcsv_parse.sv @@
// Input register, per-line state and single-pass byte processing.
module qcsv_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] byte_value
  input  logic                      s_tlast,   // line_last
  input  logic [7:0]                delimiter,
  input  logic [qcsv_pkg::CNT_W-1:0] expected_fields,
  input  logic                      load_ok,
  output logic                      batch_valid,
  output qcsv_pkg::batch_t          batch
);
  import qcsv_pkg::*;

  logic             pvalid;
  logic [7:0]       pbyte;
  logic             plast;
  pstate_t          st;
  logic [7:0]       held [2];
  logic [1:0]       held_count;

  logic             fire;
  logic [CNT_W-1:0] eff;
  logic [7:0]       tail [4];
  logic [1:0]       tail_n;
  pstate_t          st_next;
  batch_t           b_next;

  assign fire        = pvalid && load_ok;
  assign s_tready    = !pvalid || load_ok;
  assign batch_valid = pvalid;
  assign batch       = b_next;
  assign eff         = eff_expected(expected_fields);

  // Gather the line tail and strip up to two trailing CR/LF bytes.
  always_comb begin
    tail[0] = pbyte;
    tail[1] = '0;
    tail[2] = '0;
    tail[3] = '0;
    tail_n  = 2'd1;
    unique case (held_count)
      2'd0: begin
        tail_n = 2'd1;
      end
      2'd1: begin
        tail[0] = held[0];
        tail[1] = pbyte;
        tail_n  = 2'd2;
      end
      default: begin
        tail[0] = held[0];
        tail[1] = held[1];
        tail[2] = pbyte;
        tail_n  = 2'd3;
      end
    endcase
    if (tail_n != 2'd0 && is_crlf(tail[tail_n - 2'd1])) tail_n = tail_n - 2'd1;
    if (tail_n != 2'd0 && is_crlf(tail[tail_n - 2'd1])) tail_n = tail_n - 2'd1;
  end

  always_comb begin
    step_t            sr;
    pstate_t          s;
    logic [2:0]       k;
    logic [CNT_W-1:0] cnt;
    s      = st;
    k      = '0;
    b_next = '0;
    sr     = '0;
    cnt    = '0;
    if (plast) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < tail_n) begin
          sr = process_byte(s, tail[i], delimiter, eff);
          s  = sr.st;
          if (sr.emit) begin
            b_next.res[k[1:0]] = sr.res;
            k = k + 3'd1;
          end
        end
      end
      cnt = s.counter;
      b_next.res[k[1:0]].kind        = KIND_DONE;
      b_next.res[k[1:0]].field_index = cnt;
      b_next.res[k[1:0]].token_count = cnt;
      b_next.res[k[1:0]].status      = (cnt > eff) ? ST_MANY :
                                       ((cnt < eff) ? ST_FEW : ST_OK);
      k = k + 3'd1;
    end else if (held_count == 2'd2) begin
      sr = process_byte(s, held[0], delimiter, eff);
      s  = sr.st;
      if (sr.emit) begin
        b_next.res[0] = sr.res;
        k = 3'd1;
      end
    end
    if (k != 3'd0) b_next.res[2'(k - 3'd1)].run_last = 1'b1;
    b_next.count = k;
    st_next      = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid     <= 1'b0;
      st         <= '{in_quote: 1'b0, field_closed: 1'b0, counter: CNT_ONE};
      held_count <= '0;
    end else begin
      if (s_tvalid && s_tready) pvalid <= 1'b1;
      else if (fire) pvalid <= 1'b0;
      if (fire) begin
        if (plast) begin
          st         <= '{in_quote: 1'b0, field_closed: 1'b0, counter: CNT_ONE};
          held_count <= '0;
        end else begin
          st <= st_next;
          if (held_count != 2'd2) held_count <= held_count + 2'd1;
        end
      end
    end
  end

  // Payload: input word and held-back bytes.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pbyte <= s_tdata;
      plast <= s_tlast;
    end
    if (fire && !plast) begin
      if (held_count == 2'd2) begin
        held[0] <= held[1];
        held[1] <= pbyte;
      end else if (held_count == 2'd1) begin
        held[1] <= pbyte;
      end else begin
        held[0] <= pbyte;
      end
    end
  end

endmodule

@@ hdl/qcsv_out.sv @@
// Result register bank that hands results out one word per cycle while m_tready is high.
module qcsv_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             batch_valid,
  input  qcsv_pkg::batch_t batch,
  output logic             load_ok,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [6:0] field_index, [14:7] data_byte,
                                      // [16:15] status, [23:17] token_count
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast    // run_last
);
  import qcsv_pkg::*;

  result_t    slot [4];
  logic [1:0] head;
  logic [2:0] cnt;
  logic       out_fire;
  logic       load;
  result_t    cur;

  assign out_fire = m_tvalid && m_tready;
  assign load_ok  = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);
  assign load     = batch_valid && load_ok;
  assign cur      = slot[head];

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = {cur.token_count, cur.status, cur.data_byte, cur.field_index};
  assign m_tuser  = cur.kind;
  assign m_tlast  = cur.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (load) begin
      head <= '0;
      cnt  <= batch.count;
    end else if (out_fire) begin
      head <= head + 2'd1;
      cnt  <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) slot[i] <= batch.res[i];
    end
  end

endmodule

@@ hdl/quoted_csv_field_splitter_top.sv @@
// Top level of the quoted CSV field splitter: configuration and submodules.
// Usage:
//   Feed one line as bytes on s_t*, s_tlast on its final byte. Results leave
//   on m_t*: m_tuser is the kind (content, restart field, field end, line
//   done) and m_tlast closes the run of results caused by one input word.
//   Delimiter (index 0) and expected field count (index 1) are written on
//   the cfg_* channel, which is always ready; write them only while idle.
// Timing:
//   An accepted word sits in the input register until the result bank
//   takes its results, which are then registered there. Two bytes are
//   held back, so a content byte appears on the output two words after
//   it came in. Non-final words give at most one result and flow at one
//   word per cycle while m_tready stays high. A final word gives up to
//   four results, which leave through the single output port one per
//   cycle while m_tready is high.
// Reset: rst (synchronous) empties both registers, clears the line state and
//   restores delimiter 44 and expected count 1.
// Stall: with m_tready low the results hold; the input register still takes
//   one word, then s_tready drops until the result bank frees.
`include "assert_macros.svh"

module quoted_csv_field_splitter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] byte_value
  input  logic                       s_tlast,   // line_last
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,   // [6:0] field_index, [14:7] data_byte,
                                                // [16:15] status, [23:17] token_count
  output logic [1:0]                 m_tuser,   // [1:0] kind
  output logic                       m_tlast,   // run_last
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [7:0]                 cfg_data
);
  import qcsv_pkg::*;

  logic [7:0]       delimiter;
  logic [CNT_W-1:0] expected_fields;
  logic             load_ok;
  logic             batch_valid;
  batch_t           batch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter       <= DELIM_RST;
      expected_fields <= EXPECTED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER: delimiter       <= cfg_data;
        REG_EXPECTED:  expected_fields <= cfg_data[CNT_W-1:0];
        default:       delimiter       <= delimiter;
      endcase
    end
  end

  qcsv_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .delimiter       (delimiter),
    .expected_fields (expected_fields),
    .load_ok         (load_ok),
    .batch_valid     (batch_valid),
    .batch           (batch)
  );

  qcsv_out u_out (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch       (batch),
    .load_ok     (load_ok),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  `ASSERT_CLKD(a_done_ends_run, clk, rst, (m_tvalid && m_tuser == KIND_DONE) |-> m_tlast, "line done not last of run")
  `ASSERT_CLKD(a_data_zero, clk, rst, (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata[14:7] == 8'd0), "data byte set on non-content result")
  `ASSERT_CLKD(a_done_count, clk, rst, (m_tvalid && m_tuser == KIND_DONE) |-> (m_tdata[23:17] == m_tdata[6:0] && m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= CNT_SAT), "bad field count on line done")
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_tvalid, "output valid straight after reset")

endmodule

@@ tb/sv/qcsv_splitter_checker.sv @@
// Checker for the quoted CSV field splitter: predicts results from accepted words and compares.
`timescale 1ns / 1ps

module qcsv_splitter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          awaited
);
  import qcsv_pkg::*;

  result_t          field_events_q[$];
  result_t          run_tail;
  logic             run_open;

  logic [7:0]       delim_copy;
  logic [CNT_W-1:0] want_fields;
  logic             in_quote;
  logic             field_closed;
  logic [CNT_W-1:0] field_no;
  logic [7:0]       held [0:1];
  int               held_n;

  function automatic logic [CNT_W-1:0] effective_fields();
    if (want_fields == '0) return CNT_ONE;
    if (want_fields > FIELDS_MAX) return FIELDS_MAX;
    return want_fields;
  endfunction

  function automatic logic line_break(logic [7:0] b);
    return (b == CR_BYTE) || (b == LF_BYTE);
  endfunction

  // Keep the newest result back so that run_last can be set on it.
  task automatic emit(kind_t k, logic [CNT_W-1:0] idx, logic [7:0] data, status_t st,
                      logic [CNT_W-1:0] cnt);
    if (run_open) field_events_q.push_back(run_tail);
    run_tail.kind        = k;
    run_tail.field_index = idx;
    run_tail.data_byte   = data;
    run_tail.status      = st;
    run_tail.token_count = cnt;
    run_tail.run_last    = 1'b0;
    run_open = 1'b1;
  endtask

  task automatic split_byte(logic [7:0] b);
    logic kept;
    kept = (field_no <= effective_fields());
    if (b == QUOTE_BYTE) begin
      if (!in_quote) begin
        if (kept) emit(KIND_RESTART, field_no, 8'h00, ST_OK, '0);
        field_closed = 1'b0;
        in_quote = 1'b1;
      end else begin
        in_quote = 1'b0;
        field_closed = 1'b1;
      end
    end else if (b == delim_copy && !in_quote) begin
      if (kept) emit(KIND_END, field_no, 8'h00, ST_OK, '0);
      field_closed = 1'b0;
      if (field_no < CNT_SAT) field_no = field_no + CNT_ONE;
    end else if (kept && !field_closed) begin
      emit(KIND_BYTE, field_no, b, ST_OK, '0);
    end
  endtask

  task automatic clear_line();
    in_quote = 1'b0;
    field_closed = 1'b0;
    field_no = CNT_ONE;
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_n = 0;
  endtask

  task automatic take_word(logic [7:0] b, logic last);
    logic [7:0] tail [0:2];
    int         n;
    status_t    st;
    run_open = 1'b0;
    if (!last) begin
      if (held_n == 2) begin
        split_byte(held[0]);
        held[0] = held[1];
        held[1] = b;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    end else begin
      n = 0;
      for (int i = 0; i < held_n; i++) begin
        tail[n] = held[i];
        n++;
      end
      tail[n] = b;
      n++;
      // strip at most two trailing line breaks
      if (n > 0 && line_break(tail[n-1])) n--;
      if (n > 0 && line_break(tail[n-1])) n--;
      for (int i = 0; i < n; i++) split_byte(tail[i]);
      if (field_no > effective_fields()) st = ST_MANY;
      else if (field_no < effective_fields()) st = ST_FEW;
      else st = ST_OK;
      emit(KIND_DONE, field_no, 8'h00, st, field_no);
      clear_line();
    end
    if (run_open) begin
      run_tail.run_last = 1'b1;
      field_events_q.push_back(run_tail);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (field_events_q.size() == 0) begin
      $display("%0t: result with nothing awaited: kind %0d index %0d data %0d", $time,
               m_tuser, m_tdata[6:0], m_tdata[14:7]);
      fail_count++;
    end else begin
      want = field_events_q.pop_front();
      check_field("kind", 8'(want.kind), 8'(m_tuser));
      check_field("field_index", 8'(want.field_index), 8'(m_tdata[6:0]));
      check_field("data_byte", want.data_byte, m_tdata[14:7]);
      check_field("status", 8'(want.status), 8'(m_tdata[16:15]));
      check_field("token_count", 8'(want.token_count), 8'(m_tdata[23:17]));
      check_field("run_last", 8'(want.run_last), 8'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      delim_copy = DELIM_RST;
      want_fields = EXPECTED_RST;
      clear_line();
      field_events_q.delete();
    end else begin
      if (m_tvalid && m_tready) compare_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DELIMITER) delim_copy = cfg_data;
        else want_fields = cfg_data[CNT_W-1:0];
      end
      if (s_tvalid && s_tready) take_word(s_tdata, s_tlast);
    end
    awaited = field_events_q.size();
  end

endmodule

@@ tb/sv/tb_quoted_csv_field_splitter_top.sv @@
// Testbench top for the quoted CSV field splitter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_quoted_csv_field_splitter_top;
  import qcsv_pkg::*;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum int {SH_PLAIN, SH_QUOTED, SH_QUOTED_TAIL, SH_LEAD_QUOTED, SH_EMPTY_QUOTES}
    field_shape_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int          errors;
  int          awaited;
  logic        hold_req;
  int          burst_left;
  int          sent_words;
  logic [7:0]  cur_delim;
  logic [7:0]  line_buf[$];

  quoted_csv_field_splitter_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qcsv_splitter_checker line_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (errors),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: free-running, random or patterned stretches, plus one long hold-off on request.
  initial begin
    rx_mode_t mode;
    int       left;
    int       tick;
    m_tready = 1'b0;
    mode = RX_FREE;
    left = 40;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        left = $urandom_range(10, 60);
      end
      left--;
      tick++;
      case (mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
        default:   m_tready <= ((tick % 5) < 3);
      endcase
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_words++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_word(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain every awaited result, then let the bench idle before the next phase.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == cur_delim || b == QUOTE_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_delim();
    return (cur_delim == 8'h00) ? pick_content() : cur_delim;
  endfunction

  function automatic logic [7:0] pick_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return pick_delim();
    if (r < 4) return QUOTE_BYTE;
    if (r == 4) return CR_BYTE;
    if (r == 5) return LF_BYTE;
    if (r < 8) return pick_content();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_quoted(input int len);
    line_buf.push_back(QUOTE_BYTE);
    repeat (len) line_buf.push_back(($urandom_range(0, 3) == 0) ? pick_delim() : pick_content());
    line_buf.push_back(QUOTE_BYTE);
  endtask

  task automatic add_field();
    field_shape_t shape;
    shape = field_shape_t'($urandom_range(0, 4));
    case (shape)
      SH_PLAIN:        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_content());
      SH_QUOTED:       add_quoted($urandom_range(0, 3));
      SH_QUOTED_TAIL: begin
        add_quoted($urandom_range(0, 2));
        repeat ($urandom_range(1, 2)) line_buf.push_back(pick_content());
      end
      SH_LEAD_QUOTED: begin
        repeat ($urandom_range(1, 2)) line_buf.push_back(pick_content());
        add_quoted($urandom_range(1, 2));
      end
      default:         add_quoted(0);
    endcase
  endtask

  task automatic build_line(input int fields);
    line_buf.delete();
    for (int f = 0; f < fields; f++) begin
      if (f > 0) line_buf.push_back(pick_delim());
      add_field();
    end
    repeat ($urandom_range(0, 3))
      line_buf.push_back($urandom_range(0, 1) ? CR_BYTE : LF_BYTE);
    if (line_buf.size() == 0) line_buf.push_back(pick_content());
  endtask

  initial begin
    logic [7:0] d;
    logic [7:0] e;
    int         target;
    int         fields;
    int         phase_start;
    int         r;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DELIMITER;
    cfg_data = 8'h00;
    hold_req = 1'b0;
    burst_left = 0;
    sent_words = 0;
    cur_delim = DELIM_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines: comma delimiter, three fields expected.
    write_reg(REG_DELIMITER, ",");
    write_reg(REG_EXPECTED, 8'd3);
    cur_delim = ",";
    // restart on opening quote, delimiter in quotes, junk after closing quote, CR LF strip
    line_buf = '{8'h01, QUOTE_BYTE, ",", QUOTE_BYTE, "x", ",", 8'hFF, CR_BYTE, LF_BYTE};
    send_line();
    // line of a single line break
    line_buf = '{LF_BYTE};
    send_line();
    // three trailing breaks: only two go
    line_buf = '{"a", CR_BYTE, CR_BYTE, LF_BYTE};
    send_line();
    // quote never closed
    line_buf = '{QUOTE_BYTE, "q", ",", ","};
    send_line();
    // too many fields
    line_buf = '{",", ",", ",", ","};
    send_line();
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin d = 8'hFF;      e = 8'd0;   end
        1:       begin d = QUOTE_BYTE; e = 8'd2;   end
        2:       begin d = CR_BYTE;    e = 8'd4;   end
        3:       begin d = 8'h00;      e = 8'd1;   end
        4:       begin d = ",";        e = 8'd64;  end
        5:       begin d = 8'($urandom_range(1, 255)); e = 8'd127; end
        6:       begin d = 8'h09;      e = 8'($urandom_range(1, 6)); end
        default: begin d = 8'($urandom_range(0, 255)); e = 8'($urandom_range(1, 8)); end
      endcase
      write_reg(REG_DELIMITER, d);
      write_reg(REG_EXPECTED, e);
      cur_delim = d;
      target = (e == 0) ? 1 : ((e > 64) ? 64 : e);
      if (p == 2) hold_req = 1'b1;
      if (p == 4) begin
        // push the field counter into saturation
        line_buf.delete();
        repeat (68) line_buf.push_back(",");
        line_buf.push_back("z");
        send_line();
      end
      phase_start = sent_words;
      while (sent_words - phase_start < 24) begin
        r = $urandom_range(0, 9);
        fields = target + $urandom_range(0, 2) - 1;
        if (fields < 1) fields = 1;
        // keep lines short under a large expected count
        if (fields > 8) fields = $urandom_range(1, 8);
        if (r < 7) begin
          build_line(fields);
        end else if (r < 9) begin
          line_buf.delete();
          repeat ($urandom_range(1, 8)) line_buf.push_back(pick_noise());
        end else begin
          // stray quote somewhere in an otherwise sound line
          build_line(fields);
          line_buf.insert($urandom_range(0, line_buf.size()), QUOTE_BYTE);
        end
        send_line();
      end
      settle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
